@@ design/ptsz_pkg.sv @@
// Shared types and constants for the period tachometer with stall zeroing.
// Holds the item structs, opcodes, register indexes and controller interface.
// No dependencies; compile first.
package ptsz_pkg;

    // Fixed field widths
    localparam int unsigned OP_W      = 2;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned SPEED_W   = 32;
    localparam int unsigned PPR_W     = 8;
    localparam int unsigned STALE_W   = 24;
    localparam int unsigned CFG_IDX_W = 2;

    // Divider geometry: 60e6*256 needs 34 bits, ppr*period needs 40 bits
    localparam int unsigned NUM_W     = 34;
    localparam int unsigned DIV_W     = PPR_W + TIME_W;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0]   RPM_SCALED_NUM = 34'd15360000000;
    localparam logic [SPEED_W-1:0] SPEED_MAX      = '1;

    // Register reset values
    localparam logic [PPR_W-1:0]   PPR_RESET   = 8'd5;
    localparam logic [STALE_W-1:0] STALE_RESET = 24'd500000;

    // Opcodes
    localparam logic [OP_W-1:0] OP_POLL = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PPR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TIME_W-1:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_q8;
        logic [7:0]         reply_byte;
        logic               reply_valid;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic div_step;
        logic sat;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_edge;
        logic out_free;
    } t_dp_stat;

endpackage

@@ design/period_tachometer_with_stall_zero.sv @@
// Period tachometer with stall zeroing: top level.
// Joins ptsz_ctrl and ptsz_dp; depends on ptsz_pkg.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in) takes one item: a poll, a
//   sensor rising edge or a bus read request, each with its microsecond
//   timestamp. Each item yields exactly one result on the output channel
//   (o_out_valid/i_out_ready, o_out): the speed in unsigned Q24.8 rpm after
//   the item, plus a reply byte that is valid only for read requests.
//   Configuration channel (i_cfg_valid/o_cfg_ready) is always ready; index 0
//   writes pulses per revolution, index 1 the stall check interval.
// Sequencing:
//   Poll, read and unused opcodes: S_EXEC, then S_PUSH loads the result.
//   Sensor edge: S_EXEC, an 8x32 multiply in S_MUL, a 34-step restoring
//   divider in S_DIV that produces one quotient bit per cycle, S_SAT, S_PUSH.
//   One item is in work at a time; a new item is taken once the previous
//   result sits in the output register.
// Reset (synchronous, active low) clears the architectural state, loads the
// register defaults and empties the output register. A stalled receiver
// holds the result in the output register; a following item is worked on
// and then waits for that register to free up.
module period_tachometer_with_stall_zero (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ptsz_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ptsz_pkg::t_out_item             o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ptsz_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptsz_pkg::STALE_W-1:0]    i_cfg_data
);

    ptsz_pkg::t_dp_cmd  cmd;
    ptsz_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ptsz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptsz_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

@@ design/ptsz_ctrl.sv @@
// Sequencing state machine for the period tachometer.
// Depends on ptsz_pkg for the command and status structs.
module ptsz_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptsz_pkg::t_dp_stat i_stat,
    output ptsz_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_SAT  = 6'b010000,
        S_PUSH = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic [ptsz_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.is_edge ? S_MUL : S_PUSH;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + ptsz_pkg::CNT_W'(1);
                if (r_cnt == ptsz_pkg::CNT_W'(ptsz_pkg::DIV_STEPS - 1)) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                // hold until the output register can take the item
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ design/ptsz_dp.sv @@
// Datapath of the period tachometer: state registers, configuration,
// multiplier, restoring divider and output register. Depends on ptsz_pkg.
module ptsz_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptsz_pkg::t_in_item                i_in,
    input  logic                              i_cfg_valid,
    input  logic [ptsz_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptsz_pkg::STALE_W-1:0]      i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ptsz_pkg::t_out_item               o_out,
    input  ptsz_pkg::t_dp_cmd                 i_cmd,
    output ptsz_pkg::t_dp_stat                o_stat
);

    // Configuration
    logic [ptsz_pkg::PPR_W-1:0]   r_ppr;
    logic [ptsz_pkg::STALE_W-1:0] r_stale;

    // Architectural state
    logic [ptsz_pkg::SPEED_W-1:0] r_speed;
    logic [ptsz_pkg::SPEED_W-1:0] r_snap;
    logic [ptsz_pkg::TIME_W-1:0]  r_last_edge;
    logic [ptsz_pkg::TIME_W-1:0]  r_last_chk;
    logic                         r_phase;
    logic [1:0]                   r_pos;

    // Item in flight
    logic [ptsz_pkg::OP_W-1:0]    r_op;
    logic [ptsz_pkg::TIME_W-1:0]  r_now;
    logic [ptsz_pkg::TIME_W-1:0]  r_period;
    logic [7:0]                   r_reply;
    logic                         r_reply_vld;

    // Divider
    logic [ptsz_pkg::DIV_W-1:0]   r_divisor;
    logic [ptsz_pkg::DIV_W-1:0]   r_rem;
    logic [ptsz_pkg::NUM_W-1:0]   r_num;
    logic [ptsz_pkg::DIV_W:0]     trial;
    logic [ptsz_pkg::DIV_W:0]     trial_diff;
    logic                         q_bit;

    // Output register
    ptsz_pkg::t_out_item          r_out;
    logic                         r_out_valid;

    logic [ptsz_pkg::TIME_W-1:0]  elapsed;
    logic                         stale;

    assign elapsed = r_now - r_last_chk;
    assign stale   = elapsed > {{(ptsz_pkg::TIME_W - ptsz_pkg::STALE_W){1'b0}}, r_stale};

    // One restoring step: shift in the next numerator bit, subtract if it fits.
    // A zero divisor always fits, so the quotient fills with ones and saturates.
    assign trial      = {r_rem, r_num[ptsz_pkg::NUM_W-1]};
    assign trial_diff = trial - {1'b0, r_divisor};
    assign q_bit      = (trial >= {1'b0, r_divisor});

    assign o_stat.is_edge  = (r_op == ptsz_pkg::OP_EDGE);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr   <= ptsz_pkg::PPR_RESET;
            r_stale <= ptsz_pkg::STALE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ptsz_pkg::CFG_PPR) begin
                r_ppr <= i_cfg_data[ptsz_pkg::PPR_W-1:0];
            end else if (i_cfg_index == ptsz_pkg::CFG_STALE) begin
                r_stale <= i_cfg_data;
            end
        end
    end

    // Architectural state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= '0;
            r_snap      <= '0;
            r_last_edge <= '0;
            r_last_chk  <= '0;
            r_phase     <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_op)
                    ptsz_pkg::OP_POLL: begin
                        if (stale) begin
                            if (!r_phase) begin
                                // drop the speed if no edge changed it since the snapshot
                                if (r_speed == r_snap) begin
                                    r_speed <= '0;
                                end
                                r_phase <= 1'b1;
                            end else begin
                                r_snap  <= r_speed;
                                r_phase <= 1'b0;
                            end
                            r_last_chk <= r_now;
                        end
                    end
                    ptsz_pkg::OP_EDGE: begin
                        r_last_edge <= r_now;
                    end
                    ptsz_pkg::OP_READ: begin
                        r_pos <= r_pos + 2'd1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.sat) begin
                // saturate a quotient above 32 bits
                if (|r_num[ptsz_pkg::NUM_W-1:ptsz_pkg::SPEED_W]) begin
                    r_speed <= ptsz_pkg::SPEED_MAX;
                end else begin
                    r_speed <= r_num[ptsz_pkg::SPEED_W-1:0];
                end
            end
        end
    end

    // Item capture, reply, multiply and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in.opcode;
            r_now <= i_in.now_us;
        end
        if (i_cmd.exec) begin
            r_period <= r_now - r_last_edge;
            if (r_op == ptsz_pkg::OP_READ) begin
                r_reply     <= 8'(r_speed >> {r_pos, 3'b000});
                r_reply_vld <= 1'b1;
            end else begin
                r_reply     <= '0;
                r_reply_vld <= 1'b0;
            end
        end
        if (i_cmd.mul) begin
            r_divisor <= ptsz_pkg::DIV_W'(r_ppr) * ptsz_pkg::DIV_W'(r_period);
            r_rem     <= '0;
            r_num     <= ptsz_pkg::RPM_SCALED_NUM;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? trial_diff[ptsz_pkg::DIV_W-1:0]
                           : trial[ptsz_pkg::DIV_W-1:0];
            r_num <= {r_num[ptsz_pkg::NUM_W-2:0], q_bit};
        end
        if (i_cmd.load_out) begin
            r_out.speed_q8    <= r_speed;
            r_out.reply_byte  <= r_reply;
            r_out.reply_valid <= r_reply_vld;
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

@@ design/ptsz_checker.sv @@
// Port-level checks for the period tachometer, bound to the top level.
// Depends on ptsz_pkg and period_tachometer_with_stall_zero.
module ptsz_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  ptsz_pkg::t_in_item              i_in,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  ptsz_pkg::t_out_item             o_out,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [ptsz_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptsz_pkg::STALE_W-1:0]    i_cfg_data
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // Only one item in work: an accept closes the input channel
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted back to back");

    // A result without a read reply carries a zero reply byte
    a_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.reply_valid |-> o_out.reply_byte == 8'd0)
        else $error("reply byte set without read request");

endmodule

bind period_tachometer_with_stall_zero ptsz_checker u_ptsz_checker (.*);
